// File: src/rdoa_pkg.sv
// ----------------------------------------------------------------------------
// rdoa_pkg
// shared types and constants of the radix digit offset adder
// ----------------------------------------------------------------------------
`default_nettype none

package rdoa_pkg;

  // fixed field widths
  localparam int unsigned WORD_W   = 64;
  localparam int unsigned DIGIT_W  = 8;
  localparam int unsigned POS_W    = 4;
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned COUNT_W  = 5;
  localparam int unsigned CFG_IDX_W = 2;

  // narrow divide: digit sum of up to nine bits
  localparam int unsigned NARROW_W = 9;
  localparam int unsigned STEP_W   = 7;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RADIX       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIGIT_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VALUE_RANGE = 2'd2;

  // register reset values
  localparam logic [DIGIT_W-1:0] RADIX_RESET       = 8'd10;
  localparam logic [COUNT_W-1:0] DIGIT_COUNT_RESET = 5'd8;
  localparam logic [WORD_W-1:0]  VALUE_RANGE_RESET = '1;
  localparam logic [DIGIT_W-1:0] RADIX_MIN         = 8'd2;

  // status codes
  localparam logic STATUS_OK     = 1'b0;
  localparam logic STATUS_REJECT = 1'b1;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD = 2'd0,
    MODE_SET  = 2'd1,
    MODE_INC  = 2'd2
  } mode_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RANGE_WAIT,
    S_SET_STEP,
    S_SET_DIV_WAIT,
    S_SET_SUM_WAIT,
    S_INC_STEP,
    S_INC_WAIT,
    S_EMIT,
    S_LOAD_OUT
  } state_e;

  // request to the shared divider
  typedef struct packed {
    logic start;
    logic narrow;
  } div_req_t;

endpackage

`default_nettype wire

// File: src/rdoa_in_if.sv
// ----------------------------------------------------------------------------
// rdoa_in_if
// input channel: valid, ready and one item
// ----------------------------------------------------------------------------
`default_nettype none

interface rdoa_in_if import rdoa_pkg::*;;
  logic               valid;
  logic               ready;
  logic [MODE_W-1:0]  mode;
  logic [POS_W-1:0]   digit_index;
  logic [DIGIT_W-1:0] digit_value;
  logic [WORD_W-1:0]  number;
  logic               use_range;

  modport source (
    output valid, mode, digit_index, digit_value, number, use_range,
    input  ready
  );

  modport sink (
    input  valid, mode, digit_index, digit_value, number, use_range,
    output ready
  );

  modport monitor (
    input valid, ready, mode, digit_index, digit_value, number, use_range
  );
endinterface

`default_nettype wire

// File: src/rdoa_out_if.sv
// ----------------------------------------------------------------------------
// rdoa_out_if
// result channel: valid, ready and one digit beat
// ----------------------------------------------------------------------------
`default_nettype none

interface rdoa_out_if import rdoa_pkg::*;;
  logic               valid;
  logic               ready;
  logic [POS_W-1:0]   digit_position;
  logic [DIGIT_W-1:0] digit;
  logic [WORD_W-1:0]  stored_number;
  logic               status;
  logic               last;

  modport source (
    output valid, digit_position, digit, stored_number, status, last,
    input  ready
  );

  modport sink (
    input  valid, digit_position, digit, stored_number, status, last,
    output ready
  );

  modport monitor (
    input valid, ready, digit_position, digit, stored_number, status, last
  );
endinterface

`default_nettype wire

// File: src/rdoa_div.sv
// ----------------------------------------------------------------------------
// rdoa_div
// shared restoring divider, one quotient bit per cycle, 64 or 9 steps
// ----------------------------------------------------------------------------
`default_nettype none

module rdoa_div import rdoa_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire div_req_t          req_i,
  input  wire logic [WORD_W-1:0] dividend_i,
  input  wire logic [WORD_W-1:0] divisor_i,
  output logic                   done_o,
  output logic [WORD_W-1:0]      quotient_o,
  output logic [WORD_W-1:0]      remainder_o
);

  logic              busy_q;
  logic              done_q;
  logic [STEP_W-1:0] cnt_q;
  logic [WORD_W-1:0] quo_q, quo_d;
  logic [WORD_W-1:0] rem_q, rem_d;
  logic [WORD_W-1:0] div_q;

  logic [WORD_W:0]   trial;
  logic [WORD_W+1:0] diff;
  logic              fits;

  always_comb begin
    trial = {rem_q, quo_q[WORD_W-1]};
    diff  = {1'b0, trial} - {2'b00, div_q};
    fits  = ~diff[WORD_W+1];
    rem_d = fits ? diff[WORD_W-1:0] : trial[WORD_W-1:0];
    quo_d = {quo_q[WORD_W-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == STEP_W'(1));
      if (busy_q) begin
        cnt_q <= cnt_q - STEP_W'(1);
        if (cnt_q == STEP_W'(1)) begin
          busy_q <= 1'b0;
        end
      end else if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.narrow ? STEP_W'(NARROW_W) : STEP_W'(WORD_W);
      end
    end
  end

  // operand and partial result registers
  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end else if (req_i.start) begin
      rem_q <= '0;
      div_q <= divisor_i;
      quo_q <= req_i.narrow ? {dividend_i[NARROW_W-1:0], {(WORD_W-NARROW_W){1'b0}}}
                            : dividend_i;
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

`default_nettype wire

// File: src/radix_digit_offset_adder_unit.sv
// ----------------------------------------------------------------------------
// radix_digit_offset_adder_unit
// base plus number in a configurable radix, with odometer increment
// ----------------------------------------------------------------------------
// load: one result beat, offered in the cycle after acceptance
// set: range reduction when asked for, a 64-step then 9-step division in the
//   shared divider per digit the number reaches, one closing step, then one
//   digit beat per cycle while the receiver is ready
// increment: one 9-step division per digit until one stays nonzero, then beats
// one item at a time; async active-low reset restores defaults, clears state
`default_nettype none

module radix_digit_offset_adder_unit import rdoa_pkg::*; #(
  parameter int unsigned MAX_DIGITS = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [WORD_W-1:0]    cfg_data_i,
  rdoa_in_if.sink                   in_i,
  rdoa_out_if.source                out_o
);

  // digit index and digit counter widths
  localparam int unsigned IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_DIGITS + 1);

  // configuration registers
  logic [DIGIT_W-1:0] radix_q;
  logic [COUNT_W-1:0] digit_count_q;
  logic [WORD_W-1:0]  value_range_q;

  // sequencer and digit state
  state_e             state_q, state_d;
  logic [CNT_W-1:0]   i_q, i_d;
  logic [WORD_W-1:0]  x_q, x_d;
  logic [WORD_W-1:0]  last_number_q, last_number_d;
  logic [DIGIT_W-1:0] base_q [MAX_DIGITS];
  logic [DIGIT_W-1:0] base_d [MAX_DIGITS];
  logic [DIGIT_W-1:0] cur_q  [MAX_DIGITS];
  logic [DIGIT_W-1:0] cur_d  [MAX_DIGITS];

  // load result held for its beat
  logic [POS_W-1:0]   ld_idx_q, ld_idx_d;
  logic [DIGIT_W-1:0] ld_val_q, ld_val_d;
  logic               ld_st_q, ld_st_d;

  // shared divider
  div_req_t           div_req;
  logic [WORD_W-1:0]  div_dividend;
  logic [WORD_W-1:0]  div_divisor;
  logic               div_done;
  logic [WORD_W-1:0]  div_quo;
  logic [WORD_W-1:0]  div_rem;

  // derived values
  logic [DIGIT_W-1:0]    radix_eff;
  logic [6:0]            count_wide;
  logic [CNT_W-1:0]      count_eff;
  logic [DIGIT_W-1:0]    cur_rd;
  logic [NARROW_W-1:0]   sum_digit;
  logic [NARROW_W-1:0]   inc_digit;
  logic [CNT_W+POS_W-1:0] pos_wide;
  logic                  beat_last;

  rdoa_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (div_req),
    .dividend_i  (div_dividend),
    .divisor_i   (div_divisor),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  // radix below two counts as two; digit count clamped to 1..MAX_DIGITS
  always_comb begin
    radix_eff = (radix_q < RADIX_MIN) ? RADIX_MIN : radix_q;
    if (digit_count_q == '0) begin
      count_wide = 7'd1;
    end else if (7'(digit_count_q) > 7'(MAX_DIGITS)) begin
      count_wide = 7'(MAX_DIGITS);
    end else begin
      count_wide = 7'(digit_count_q);
    end
    count_eff = CNT_W'(count_wide);
  end

  assign cur_rd    = cur_q[i_q[IDX_W-1:0]];
  assign sum_digit = {1'b0, cur_rd} + {1'b0, div_rem[DIGIT_W-1:0]};
  assign inc_digit = {1'b0, cur_rd} + NARROW_W'(1);
  assign pos_wide  = {{POS_W{1'b0}}, i_q};
  assign beat_last = (i_q == count_eff - CNT_W'(1));

  // configuration write port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q       <= RADIX_RESET;
      digit_count_q <= DIGIT_COUNT_RESET;
      value_range_q <= VALUE_RANGE_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_RADIX:       radix_q       <= cfg_data_i[DIGIT_W-1:0];
        CFG_DIGIT_COUNT: digit_count_q <= cfg_data_i[COUNT_W-1:0];
        CFG_VALUE_RANGE: value_range_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // state and digit vectors
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      i_q           <= '0;
      last_number_q <= '0;
      for (int j = 0; j < MAX_DIGITS; j++) begin
        base_q[j] <= '0;
        cur_q[j]  <= '0;
      end
    end else begin
      state_q       <= state_d;
      i_q           <= i_d;
      last_number_q <= last_number_d;
      base_q        <= base_d;
      cur_q         <= cur_d;
    end
  end

  // working number and load beat payload
  always_ff @(posedge clk_i) begin
    x_q      <= x_d;
    ld_idx_q <= ld_idx_d;
    ld_val_q <= ld_val_d;
    ld_st_q  <= ld_st_d;
  end

  // sequencer
  always_comb begin
    state_d       = state_q;
    i_d           = i_q;
    x_d           = x_q;
    last_number_d = last_number_q;
    base_d        = base_q;
    cur_d         = cur_q;
    ld_idx_d      = ld_idx_q;
    ld_val_d      = ld_val_q;
    ld_st_d       = ld_st_q;

    div_req      = '0;
    div_dividend = '0;
    div_divisor  = {{(WORD_W-DIGIT_W){1'b0}}, radix_eff};

    in_i.ready           = 1'b0;
    out_o.valid          = 1'b0;
    out_o.digit_position = pos_wide[POS_W-1:0];
    out_o.digit          = cur_rd;
    out_o.stored_number  = last_number_q;
    out_o.status         = STATUS_OK;
    out_o.last           = beat_last;

    unique case (state_q)
      S_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          unique case (mode_e'(in_i.mode))
            MODE_LOAD: begin
              ld_idx_d = in_i.digit_index;
              ld_val_d = in_i.digit_value;
              if (in_i.digit_value >= radix_eff) begin
                ld_st_d = STATUS_REJECT;
              end else begin
                ld_st_d = STATUS_OK;
                // an index beyond storage hits no entry and changes nothing
                for (int j = 0; j < MAX_DIGITS; j++) begin
                  if ({3'b000, in_i.digit_index} == 7'(j)) begin
                    base_d[j] = in_i.digit_value;
                  end
                end
                if ({3'b000, in_i.digit_index} < 7'(MAX_DIGITS)) begin
                  cur_d = base_d;
                end
              end
              state_d = S_LOAD_OUT;
            end
            MODE_SET: begin
              if (in_i.use_range && (value_range_q != '0)) begin
                div_req.start = 1'b1;
                div_dividend  = in_i.number;
                div_divisor   = value_range_q;
                state_d       = S_RANGE_WAIT;
              end else begin
                x_d           = in_i.number;
                last_number_d = in_i.number;
                cur_d         = base_q;
                i_d           = '0;
                state_d       = S_SET_STEP;
              end
            end
            MODE_INC: begin
              i_d     = '0;
              state_d = S_INC_STEP;
            end
            default: ;
          endcase
        end
      end

      S_RANGE_WAIT: begin
        if (div_done) begin
          x_d           = div_rem;
          last_number_d = div_rem;
          cur_d         = base_q;
          i_d           = '0;
          state_d       = S_SET_STEP;
        end
      end

      // stop as soon as number and carry are used up
      S_SET_STEP: begin
        if ((i_q < count_eff) && (x_q != '0)) begin
          div_req.start = 1'b1;
          div_dividend  = x_q;
          state_d       = S_SET_DIV_WAIT;
        end else begin
          i_d     = '0;
          state_d = S_EMIT;
        end
      end

      // low digit known: fold it into the base digit
      S_SET_DIV_WAIT: begin
        if (div_done) begin
          x_d            = div_quo;
          div_req.start  = 1'b1;
          div_req.narrow = 1'b1;
          div_dividend   = {{(WORD_W-NARROW_W){1'b0}}, sum_digit};
          state_d        = S_SET_SUM_WAIT;
        end
      end

      S_SET_SUM_WAIT: begin
        if (div_done) begin
          x_d = x_q + div_quo;
          for (int j = 0; j < MAX_DIGITS; j++) begin
            if (i_q == CNT_W'(j)) begin
              cur_d[j] = div_rem[DIGIT_W-1:0];
            end
          end
          i_d     = i_q + CNT_W'(1);
          state_d = S_SET_STEP;
        end
      end

      S_INC_STEP: begin
        if (i_q < count_eff) begin
          div_req.start  = 1'b1;
          div_req.narrow = 1'b1;
          div_dividend   = {{(WORD_W-NARROW_W){1'b0}}, inc_digit};
          state_d        = S_INC_WAIT;
        end else begin
          i_d     = '0;
          state_d = S_EMIT;
        end
      end

      // carry ripples on only while the digit wraps to zero
      S_INC_WAIT: begin
        if (div_done) begin
          for (int j = 0; j < MAX_DIGITS; j++) begin
            if (i_q == CNT_W'(j)) begin
              cur_d[j] = div_rem[DIGIT_W-1:0];
            end
          end
          if (div_rem[DIGIT_W-1:0] != '0) begin
            i_d     = '0;
            state_d = S_EMIT;
          end else begin
            i_d     = i_q + CNT_W'(1);
            state_d = S_INC_STEP;
          end
        end
      end

      S_EMIT: begin
        out_o.valid = 1'b1;
        if (out_o.ready) begin
          if (beat_last) begin
            i_d     = '0;
            state_d = S_IDLE;
          end else begin
            i_d = i_q + CNT_W'(1);
          end
        end
      end

      S_LOAD_OUT: begin
        out_o.valid          = 1'b1;
        out_o.digit_position = ld_idx_q;
        out_o.digit          = ld_val_q;
        out_o.status         = ld_st_q;
        out_o.last           = 1'b1;
        if (out_o.ready) begin
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// File: src/rdoa_checker.sv
// ----------------------------------------------------------------------------
// rdoa_checker
// port-level checks of the radix digit offset adder, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module rdoa_checker import rdoa_pkg::*; (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_ready_i,
  input wire logic               out_valid_i,
  input wire logic               out_ready_i,
  input wire logic [POS_W-1:0]   out_pos_i,
  input wire logic [DIGIT_W-1:0] out_digit_i,
  input wire logic               out_status_i,
  input wire logic               out_last_i
);

  // one item at a time: no input taken while a beat is offered
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_i && out_valid_i))
    else $error("input ready while a result beat is offered");

  // the closing beat ends the item
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_ready_i && out_last_i) |=> !out_valid_i)
    else $error("result beat offered after the closing beat");

  // a rejected load is a single beat
  a_reject_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_status_i) |-> out_last_i)
    else $error("reject status on a beat that is not the last");

  // a stalled beat holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(out_pos_i) && $stable(out_digit_i)))
    else $error("stalled result beat changed");

endmodule

bind radix_digit_offset_adder_unit rdoa_checker u_rdoa_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_pos_i    (out_o.digit_position),
  .out_digit_i  (out_o.digit),
  .out_status_i (out_o.status),
  .out_last_i   (out_o.last)
);

`default_nettype wire

// File: tb/radix_digit_offset_adder_unit_checker.sv
// ----------------------------------------------------------------------------
// radix_digit_offset_adder_unit_checker
// watches the register port and both channels, predicts the digit beats of
// every accepted item and compares the unit's beats against them in order
// ----------------------------------------------------------------------------
module radix_digit_offset_adder_unit_checker import rdoa_pkg::*; #(
  parameter int unsigned MAX_DIGITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [WORD_W-1:0]    cfg_data_i,
  rdoa_in_if.monitor           in_mon_i,
  rdoa_out_if.monitor          out_mon_i,
  output int unsigned          mismatches_o,
  output int unsigned          beats_due_o,
  output int unsigned          beats_seen_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned REPORT_LIMIT = 10;

  typedef struct packed {
    logic [POS_W-1:0]   pos;
    logic [DIGIT_W-1:0] digit;
    logic [WORD_W-1:0]  stored;
    logic               status;
    logic               last;
  } digit_beat_t;

  logic [DIGIT_W-1:0] radix_q;
  logic [COUNT_W-1:0] count_q;
  logic [WORD_W-1:0]  range_q;
  logic [DIGIT_W-1:0] base_q [MAX_DIGITS];
  logic [DIGIT_W-1:0] cur_q  [MAX_DIGITS];
  logic [WORD_W-1:0]  stored_q;

  digit_beat_t digits_due [$];
  int unsigned mismatch_n = 0;
  int unsigned seen_n     = 0;
  int unsigned due_n      = 0;

  assign mismatches_o = mismatch_n;
  assign beats_due_o  = due_n;
  assign beats_seen_o = seen_n;

  task automatic flag_beat(input string what, input digit_beat_t want, input digit_beat_t got);
    mismatch_n++;
    if (mismatch_n <= REPORT_LIMIT) begin
      $display("%0t ns %s: want pos %0d digit %0d number %0h status %0b last %0b",
               $time, what, want.pos, want.digit, want.stored, want.status, want.last);
      $display("          got  pos %0d digit %0d number %0h status %0b last %0b",
               got.pos, got.digit, got.stored, got.status, got.last);
    end
  endtask

  // current digits, least significant first, last marker on the top one
  task automatic queue_digits(input int unsigned cnt);
    int unsigned i;
    digit_beat_t b;
    for (i = 0; i < cnt; i++) begin
      b.pos    = POS_W'(i);
      b.digit  = cur_q[i];
      b.stored = stored_q;
      b.status = STATUS_OK;
      b.last   = (i + 1 == cnt);
      digits_due.push_back(b);
    end
  endtask

  task automatic advance_digits(input logic [MODE_W-1:0] mode, input logic [POS_W-1:0] idx,
                                input logic [DIGIT_W-1:0] dval, input logic [WORD_W-1:0] num,
                                input logic use_range);
    int unsigned       rdx, cnt, s, i;
    logic [WORD_W-1:0] x, rdx_w;
    digit_beat_t       b;
    rdx   = (radix_q < RADIX_MIN) ? RADIX_MIN : radix_q;
    cnt   = (count_q == 0) ? 1 : ((count_q > MAX_DIGITS) ? MAX_DIGITS : count_q);
    rdx_w = WORD_W'(rdx);
    case (mode)
      MODE_LOAD: begin
        b.status = STATUS_OK;
        if (dval >= rdx) begin
          b.status = STATUS_REJECT;
        end else if (idx < MAX_DIGITS) begin
          base_q[idx] = dval;
          cur_q = base_q;
        end
        b.pos    = idx;
        b.digit  = dval;
        b.stored = stored_q;
        b.last   = 1'b1;
        digits_due.push_back(b);
      end
      MODE_SET: begin
        x = num;
        if (use_range && range_q != '0) x = x % range_q;
        stored_q = x;
        cur_q = base_q;
        // digits beyond the reach of the number keep their base value
        for (i = 0; i < cnt && x != '0; i++) begin
          s = cur_q[i] + 32'(x % rdx_w);
          x = x / rdx_w;
          x = x + WORD_W'(s / rdx);
          cur_q[i] = DIGIT_W'(s % rdx);
        end
        queue_digits(cnt);
      end
      MODE_INC: begin
        for (i = 0; i < cnt; i++) begin
          cur_q[i] = DIGIT_W'((cur_q[i] + 32'd1) % rdx);
          if (cur_q[i] != '0) break;
        end
        queue_digits(cnt);
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    digit_beat_t got, want;
    if (!rst_ni) begin
      radix_q  = RADIX_RESET;
      count_q  = DIGIT_COUNT_RESET;
      range_q  = VALUE_RANGE_RESET;
      stored_q = '0;
      base_q   = '{default: '0};
      cur_q    = '{default: '0};
      digits_due.delete();
    end else begin
      if (out_mon_i.valid && out_mon_i.ready) begin
        got.pos    = out_mon_i.digit_position;
        got.digit  = out_mon_i.digit;
        got.stored = out_mon_i.stored_number;
        got.status = out_mon_i.status;
        got.last   = out_mon_i.last;
        seen_n++;
        if (digits_due.size() == 0) begin
          flag_beat("beat with nothing due", '0, got);
        end else begin
          want = digits_due.pop_front();
          if (got !== want) flag_beat("beat differs", want, got);
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_RADIX:       radix_q = cfg_data_i[DIGIT_W-1:0];
          CFG_DIGIT_COUNT: count_q = cfg_data_i[COUNT_W-1:0];
          CFG_VALUE_RANGE: range_q = cfg_data_i;
          default: ;
        endcase
      end
      if (in_mon_i.valid && in_mon_i.ready) begin
        advance_digits(in_mon_i.mode, in_mon_i.digit_index, in_mon_i.digit_value,
                       in_mon_i.number, in_mon_i.use_range);
      end
    end
    due_n = digits_due.size();
  end

endmodule

// File: tb/radix_digit_offset_adder_unit_tb.sv
// ----------------------------------------------------------------------------
// radix_digit_offset_adder_unit_tb
// drives load, set and increment items through a range of radix, digit count
// and range settings, with bursty input and a stalling receiver; the checker
// beside the unit predicts and compares every digit beat
// ----------------------------------------------------------------------------
module radix_digit_offset_adder_unit_tb import rdoa_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_DIGITS     = 16;
  localparam int unsigned RESET_CYCLES   = 12;
  // a load is answered by a single beat and the unused mode is dropped,
  // so a short settle covers any item still in flight once nothing is due
  localparam int unsigned SETTLE_CYCLES  = 24;
  localparam int unsigned DRAIN_LIMIT    = 200_000;
  // longer than the slowest item, so a beat is always left waiting
  localparam int unsigned RX_HOLD_CYCLES = 2000;

  // the one mode code the package leaves unnamed
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_RANDOM,
    RX_PERIODIC
  } rx_style_e;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [WORD_W-1:0]    cfg_data_i;

  rdoa_in_if  in_ch ();
  rdoa_out_if out_ch ();

  int unsigned mismatches, beats_due, beats_seen;

  // settings last written, used to aim the stimulus
  logic [DIGIT_W-1:0] radix_set;
  logic [COUNT_W-1:0] count_set;
  logic [WORD_W-1:0]  range_set;

  // sender bursts and the receiver's long hold-off request
  int unsigned burst_left  = 0;
  int unsigned hold_reqs   = 0;
  int unsigned hold_served = 0;

  // tallies for the closing summary
  int unsigned loads_sent = 0, sets_sent = 0, incs_sent = 0, ignored_sent = 0;
  int unsigned reg_writes = 0;

  radix_digit_offset_adder_unit #(
    .MAX_DIGITS (MAX_DIGITS)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  radix_digit_offset_adder_unit_checker #(
    .MAX_DIGITS (MAX_DIGITS)
  ) i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_mon_i     (in_ch),
    .out_mon_i    (out_ch),
    .mismatches_o (mismatches),
    .beats_due_o  (beats_due),
    .beats_seen_o (beats_seen)
  );

  // 10 ns clock
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // hard stop, far beyond the slowest honest run
  initial begin
    #40ms;
    $display("Regression FAIL");
    $finish;
  end

  // receiver: changes ready on the falling edge, switching between open,
  // random and periodic stretches; a hold-off request parks it for a long
  // fixed stretch counted here, so the unit backs up into its input
  initial begin : receiver
    int unsigned seg_left, tick;
    rx_style_e   style;
    seg_left = 0;
    tick     = 0;
    style    = RX_OPEN;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_served != hold_reqs) begin
        hold_served++;
        out_ch.ready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(negedge clk_i);
      end
      if (seg_left == 0) begin
        style    = rx_style_e'($urandom_range(0, 2));
        seg_left = $urandom_range(16, 160);
      end
      seg_left--;
      tick++;
      case (style)
        RX_OPEN:   out_ch.ready <= 1'b1;
        RX_RANDOM: out_ch.ready <= ($urandom_range(0, 3) != 0);
        default:   out_ch.ready <= ((tick % 7) < 4);
      endcase
    end
  end

  function automatic int unsigned eff_radix();
    return (radix_set < RADIX_MIN) ? RADIX_MIN : radix_set;
  endfunction

  // numbers of every size, plus values around the range modulus
  function automatic logic [WORD_W-1:0] pick_number();
    logic [WORD_W-1:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: ;
      1: v = v >> $urandom_range(1, 63);
      2: v = WORD_W'($urandom_range(0, 400));
      3: v = range_set - WORD_W'($urandom_range(0, 1));
      4: v = '1;
      default: v = v >> 44;
    endcase
    return v;
  endfunction

  // one beat on the input channel; valid drops only for a gap between bursts
  task automatic send_item(input logic [MODE_W-1:0] mode, input logic [POS_W-1:0] idx,
                           input logic [DIGIT_W-1:0] dval, input logic [WORD_W-1:0] num,
                           input logic use_range);
    @(negedge clk_i);
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_ch.valid       <= 1'b1;
    in_ch.mode        <= mode;
    in_ch.digit_index <= idx;
    in_ch.digit_value <= dval;
    in_ch.number      <= num;
    in_ch.use_range   <= use_range;
    do @(posedge clk_i); while (!in_ch.ready);
    case (mode)
      MODE_LOAD: loads_sent++;
      MODE_SET:  sets_sent++;
      MODE_INC:  incs_sent++;
      default:   ignored_sent++;
    endcase
  endtask

  // sender stands still until every predicted beat has come back
  task automatic drain();
    int unsigned guard;
    guard = 0;
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (beats_due != 0 && guard < DRAIN_LIMIT) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    reg_writes++;
  endtask

  task automatic set_config(input logic [DIGIT_W-1:0] rdx, input logic [COUNT_W-1:0] cnt,
                            input logic [WORD_W-1:0] rng);
    write_reg(CFG_RADIX, WORD_W'(rdx));
    write_reg(CFG_DIGIT_COUNT, WORD_W'(cnt));
    write_reg(CFG_VALUE_RANGE, rng);
    radix_set = rdx;
    count_set = cnt;
    range_set = rng;
  endtask

  // loads, sets and odometer steps in random order, with a tenth of the
  // loads out of range and a sprinkle of unused-mode items
  task automatic random_items(input int unsigned n);
    int unsigned        done_n, roll, r;
    logic [DIGIT_W-1:0] dval;
    done_n = 0;
    r = eff_radix();
    while (done_n < n) begin
      roll = $urandom_range(0, 99);
      if (roll < 4) begin
        send_item(MODE_UNUSED, POS_W'($urandom), DIGIT_W'($urandom), pick_number(),
                  1'($urandom));
      end else begin
        done_n++;
        if (roll < 34) begin
          if ($urandom_range(0, 9) == 0) dval = DIGIT_W'($urandom_range(r, 255));
          else                           dval = DIGIT_W'($urandom_range(0, r - 1));
          send_item(MODE_LOAD, POS_W'($urandom_range(0, 15)), dval, pick_number(),
                    1'($urandom));
        end else if (roll < 72) begin
          send_item(MODE_SET, POS_W'($urandom), DIGIT_W'($urandom), pick_number(),
                    1'($urandom));
        end else begin
          send_item(MODE_INC, POS_W'($urandom), DIGIT_W'($urandom), pick_number(),
                    1'($urandom));
        end
      end
    end
  endtask

  initial begin : stimulus
    int unsigned k;

    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_idx_i         = CFG_RADIX;
    cfg_data_i        = '0;
    in_ch.valid       = 1'b0;
    in_ch.mode        = MODE_LOAD;
    in_ch.digit_index = '0;
    in_ch.digit_value = '0;
    in_ch.number      = '0;
    in_ch.use_range   = 1'b0;
    radix_set         = RADIX_RESET;
    count_set         = DIGIT_COUNT_RESET;
    range_set         = VALUE_RANGE_RESET;

    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed part, under the reset settings (radix 10, eight digits)
    send_item(MODE_LOAD, 4'd0, 8'd9, '0, 1'b0);
    send_item(MODE_LOAD, 4'd15, 8'd0, '1, 1'b1);       // slot above the digits in use
    send_item(MODE_LOAD, 4'd3, 8'd10, '0, 1'b0);       // digit equal to the radix, rejected
    send_item(MODE_LOAD, 4'd7, 8'hFF, '0, 1'b0);       // widest digit, rejected
    send_item(MODE_SET, 4'd0, 8'd0, '0, 1'b0);         // zero touches no digit
    send_item(MODE_SET, 4'd0, 8'd0, '1, 1'b0);         // all ones, carry out dropped
    send_item(MODE_SET, 4'd0, 8'd0, '1, 1'b1);         // reduced to zero by the full range
    send_item(MODE_SET, 4'd5, 8'hAA, 64'd99_999_999, 1'b1);
    send_item(MODE_INC, 4'd0, 8'd0, '0, 1'b0);
    send_item(MODE_INC, 4'hF, 8'hFF, '1, 1'b1);
    send_item(MODE_UNUSED, 4'hF, 8'hFF, '1, 1'b1);     // must leave no trace
    // all nines: one more wraps every digit and the carry falls off the top
    for (k = 0; k < 8; k++) send_item(MODE_LOAD, POS_W'(k), 8'd9, '0, 1'b0);
    send_item(MODE_SET, 4'd0, 8'd0, 64'd1, 1'b0);
    send_item(MODE_INC, 4'd0, 8'd0, '0, 1'b0);
    send_item(MODE_INC, 4'd0, 8'd0, '0, 1'b0);
    drain();

    // register extremes: binary with every digit, then the widest radix with
    // a zero range so numbers pass unreduced
    set_config(8'd2, 5'd16, '1);
    random_items(50);
    drain();
    set_config(8'd255, 5'd16, '0);
    random_items(50);
    drain();

    // receiver parks for a long stretch while the sender keeps offering;
    // base digits left from radix 255 now lie above the radix
    set_config(8'd3, 5'd5, 64'd1000);
    hold_reqs++;
    random_items(50);
    drain();

    // radix and digit count below their floor, every range-reduced number becomes zero
    set_config(8'd0, 5'd0, 64'd1);
    random_items(40);
    drain();

    // radix one and a count above the storage
    set_config(8'd1, 5'd31, 64'd7);
    random_items(40);
    drain();

    set_config(8'd16, 5'd17, {$urandom, $urandom});
    hold_reqs++;
    random_items(40);
    drain();

    set_config(8'd255, 5'd1, '1);
    random_items(40);
    drain();

    // a few random settings to finish
    repeat (3) begin
      set_config(DIGIT_W'($urandom_range(0, 255)), COUNT_W'($urandom_range(0, 31)),
                 ($urandom_range(0, 1) != 0) ? {$urandom, $urandom}
                                             : WORD_W'($urandom_range(1, 5000)));
      random_items(30);
      drain();
    end

    $display("covered %0d load, %0d set, %0d increment and %0d unused-mode items",
             loads_sent, sets_sent, incs_sent, ignored_sent);
    $display("over %0d register writes; %0d digit beats compared, %0d mismatches",
             reg_writes, beats_seen, mismatches);
    if (mismatches == 0 && beats_due == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
